FILE: design/ucf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared types and constants of the universal comb filter.
// ----------------------------------------------------------------------------
package ucf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam int SETTLE_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_DELAY = 3'd4;

  localparam logic signed [GAIN_W-1:0] BLEND_GAIN_RST = 16'sd16384;
  localparam logic [DELAY_W-1:0]       DELAY_RST      = 16'd1;
  localparam logic [SETTLE_W-1:0]      SETTLE_CYCLES  = 2'd2;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 34'sd8192;
  localparam logic signed [ACC_W-FRAC_BITS-1:0] SAT_MAX = 20'sd32767;
  localparam logic signed [ACC_W-FRAC_BITS-1:0] SAT_MIN = -20'sd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage : ucf_pkg
`default_nettype wire

FILE: design/universal_comb_filter.sv
`default_nettype none
// Pipeline: an accepted item passes the s1 and s2 registers; its result enters the output queue from s2.
// Throughput: 1 item per cycle while the output queue has room; a delay of 1 or 2
// samples reaching into an item still in the 2-stage multiply/round pipeline stalls
// input until its write-back. Input also stalls after each configuration write.
// Reset: gains and delays take their defaults; both histories read as zero until
// written, tracked by the write pointer and a wrap flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// universal_comb_filter
// Comb filter with dry, feedforward and feedback paths over two history RAMs
// sharing one write pointer; Q2.14 gains, rounded and saturated output.
// ----------------------------------------------------------------------------
module universal_comb_filter
  import ucf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [SAMPLE_W-1:0]   in_sample_in,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [SAMPLE_W-1:0]   out_sample_out,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

  // configuration
  gain_t  blend_gain_r, feedback_gain_r, feedforward_gain_r;
  delay_t feedback_delay_r, feedforward_delay_r;
  delay_t fb_red_r, ff_red_r;
  logic [SETTLE_W-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_gain_r        <= BLEND_GAIN_RST;
      feedback_gain_r     <= '0;
      feedforward_gain_r  <= '0;
      feedback_delay_r    <= DELAY_RST;
      feedforward_delay_r <= DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_GAIN:        blend_gain_r        <= gain_t'(cfg_wdata);
        REG_FEEDBACK_GAIN:     feedback_gain_r     <= gain_t'(cfg_wdata);
        REG_FEEDFORWARD_GAIN:  feedforward_gain_r  <= gain_t'(cfg_wdata);
        REG_FEEDBACK_DELAY:    feedback_delay_r    <= delay_t'(cfg_wdata);
        REG_FEEDFORWARD_DELAY: feedforward_delay_r <= delay_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else if (cfg_we) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // reduce delays modulo the history depth
  generate
    if (HISTORY_DEPTH > 65535) begin : g_red_direct
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fb_red_r <= DELAY_RST;
          ff_red_r <= DELAY_RST;
        end else begin
          fb_red_r <= feedback_delay_r;
          ff_red_r <= feedforward_delay_r;
        end
      end
    end else begin : g_red_recip
      localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(HISTORY_DEPTH) - 64'd1)
                                          / 64'(HISTORY_DEPTH));
      localparam logic [DELAY_W-1:0] DEPTH_D = DELAY_W'(HISTORY_DEPTH);
      logic [DELAY_W+32:0] fb_prod, ff_prod;
      delay_t fb_q_r, ff_q_r, fb_raw_r, ff_raw_r;
      logic [2*DELAY_W-1:0] fb_qd, ff_qd;

      assign fb_prod = 49'(feedback_delay_r) * 49'(RECIP);
      assign ff_prod = 49'(feedforward_delay_r) * 49'(RECIP);
      assign fb_qd   = 32'(fb_q_r) * 32'(DEPTH_D);
      assign ff_qd   = 32'(ff_q_r) * 32'(DEPTH_D);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fb_q_r   <= '0;
          ff_q_r   <= '0;
          fb_raw_r <= DELAY_RST;
          ff_raw_r <= DELAY_RST;
          fb_red_r <= DELAY_RST;
          ff_red_r <= DELAY_RST;
        end else begin
          fb_q_r   <= fb_prod[DELAY_W+31:32];
          ff_q_r   <= ff_prod[DELAY_W+31:32];
          fb_raw_r <= feedback_delay_r;
          ff_raw_r <= feedforward_delay_r;
          fb_red_r <= fb_raw_r - fb_qd[DELAY_W-1:0];
          ff_red_r <= ff_raw_r - ff_qd[DELAY_W-1:0];
        end
      end
    end
  endgenerate

  // write pointer, fill tracking, tap addresses
  logic [AW-1:0] wp_r;
  logic          wrapped_r;
  logic [CW-1:0] wp_e, ff_e, fb_e, ff_full, fb_full;
  logic [AW-1:0] ff_addr, fb_addr;
  logic          ff_ok, fb_ok;

  always_comb begin
    wp_e    = CW'(wp_r);
    ff_e    = CW'(ff_red_r);
    fb_e    = CW'(fb_red_r);
    ff_full = (wp_e >= ff_e) ? (wp_e - ff_e) : (wp_e + DEPTH_C - ff_e);
    fb_full = (wp_e >= fb_e) ? (wp_e - fb_e) : (wp_e + DEPTH_C - fb_e);
    ff_addr = ff_full[AW-1:0];
    fb_addr = fb_full[AW-1:0];
    ff_ok   = wrapped_r || (ff_addr < wp_r);
    fb_ok   = wrapped_r || (fb_addr < wp_r);
  end

  // pipeline and flow control
  logic                s1_vld_r, s2_vld_r;
  sample_t             s1_x_r, s2_x_r;
  logic [AW-1:0]       s1_pos_r, s2_pos_r;
  logic                s1_ffok_r, s1_fbok_r;
  sample_t             xd_rd_r, yd_rd_r;
  prod_t               pb_r, pf_r, pk_r;
  logic [1:0]          inflight;
  logic [FIFO_CW-1:0]  fifo_cnt_r, occupancy;
  logic                hazard, in_accept, pop;

  always_comb begin
    inflight  = 2'(s1_vld_r) + 2'(s2_vld_r);
    occupancy = fifo_cnt_r + FIFO_CW'(inflight);
    hazard    = ((ff_red_r != '0) && (ff_red_r <= delay_t'(inflight)))
             || ((fb_red_r != '0) && (fb_red_r <= delay_t'(inflight)));
    in_stall  = (settle_r != '0) || (occupancy >= FIFO_CW'(FIFO_DEPTH)) || hazard;
    in_accept = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= in_accept;
      s2_vld_r <= s1_vld_r;
      if (in_accept) begin
        wp_r <= (wp_r == LAST_POS) ? '0 : wp_r + 1'b1;
        if (wp_r == LAST_POS) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r    <= sample_t'(in_sample_in);
      s1_pos_r  <= wp_r;
      s1_ffok_r <= ff_ok;
      s1_fbok_r <= fb_ok;
    end
    s2_x_r   <= s1_x_r;
    s2_pos_r <= s1_pos_r;
    pb_r     <= s1_x_r * blend_gain_r;
    pf_r     <= (s1_ffok_r ? xd_rd_r : sample_t'('0)) * feedforward_gain_r;
    pk_r     <= (s1_fbok_r ? yd_rd_r : sample_t'('0)) * feedback_gain_r;
  end

  // history memories
  sample_t x_hist_r [HISTORY_DEPTH];
  sample_t y_hist_r [HISTORY_DEPTH];
  sample_t y_new;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      x_hist_r[s2_pos_r] <= s2_x_r;
    end
    if (in_accept) begin
      xd_rd_r <= x_hist_r[ff_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      y_hist_r[s2_pos_r] <= y_new;
    end
    if (in_accept) begin
      yd_rd_r <= y_hist_r[fb_addr];
    end
  end

  // round and saturate
  acc_t                             acc;
  logic signed [ACC_W-FRAC_BITS-1:0] scaled;

  always_comb begin
    acc    = acc_t'(pb_r) + acc_t'(pf_r) + acc_t'(pk_r) + ROUND_HALF;
    scaled = (ACC_W-FRAC_BITS)'(acc >>> FRAC_BITS);
    if (scaled > SAT_MAX) begin
      y_new = sample_t'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      y_new = sample_t'(SAT_MIN);
    end else begin
      y_new = sample_t'(scaled);
    end
  end

  // output queue
  sample_t            fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] fifo_wp_r, fifo_rp_r;

  assign out_valid      = (fifo_cnt_r != '0);
  assign out_sample_out = fifo_r[fifo_rp_r];
  assign pop            = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(s2_vld_r) - FIFO_CW'(pop);
      if (s2_vld_r) begin
        fifo_wp_r <= fifo_wp_r + 1'b1;
      end
      if (pop) begin
        fifo_rp_r <= fifo_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      fifo_r[fifo_wp_r] <= y_new;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_accept)
    else $error("item accepted right after a configuration write");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue credit exceeded");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ((fifo_cnt_r < FIFO_CW'(FIFO_DEPTH)) || pop))
    else $error("output queue overflow");

  a_no_short_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_vld_r) |-> ((ff_red_r != 16'd1) && (fb_red_r != 16'd1)))
    else $error("tap read of an item not yet written back");
`endif

endmodule : universal_comb_filter
`default_nettype wire

FILE: verif/tb_universal_comb_filter.sv
// ----------------------------------------------------------------------------
// tb_universal_comb_filter
// Self-checking bench for the comb filter. A directed table covers gain
// extremes, rounding ties, saturation, delay wrap and ignored register
// writes. Random phases follow, each with new gains and delays. Every
// result is compared in order with its table value or a bit-accurate
// filter model that keeps its own input and output histories.
// ----------------------------------------------------------------------------
module tb_universal_comb_filter
  import ucf_pkg::*;
();

  localparam int                   HIST_DEPTH      = 65536;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int                   RAND_PHASES     = 14;
  localparam int                   PHASE_ITEMS     = 100;

  typedef struct packed {
    logic                  is_cfg;
    logic                  fixed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [SAMPLE_W-1:0]   val;
    logic [SAMPLE_W-1:0]   want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample_in = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire                   in_stall;
  wire                   out_valid;
  wire  [SAMPLE_W-1:0]   out_sample_out;

  logic [SAMPLE_W-1:0] dry_hist [0:HIST_DEPTH-1];
  logic [SAMPLE_W-1:0] wet_hist [0:HIST_DEPTH-1];
  logic [15:0]         wr_pos;
  gain_t               blend_q;
  gain_t               fb_gain_q;
  gain_t               ff_gain_q;
  delay_t              fb_delay_q;
  delay_t              ff_delay_q;

  logic [SAMPLE_W-1:0] pending_samples [$];
  step_t               directed_steps [$];
  int                  mismatches = 0;
  int                  gap_pct = 0;
  int                  stall_pct = 0;

  universal_comb_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] comb_predict(input logic [SAMPLE_W-1:0] x);
    logic [15:0]         ff_idx;
    logic [15:0]         fb_idx;
    logic [SAMPLE_W-1:0] ff_tap;
    logic [SAMPLE_W-1:0] fb_tap;
    longint              acc;
    longint              q;
    logic [SAMPLE_W-1:0] y;
    ff_idx = wr_pos - ff_delay_q;
    fb_idx = wr_pos - fb_delay_q;
    ff_tap = dry_hist[ff_idx];
    fb_tap = wet_hist[fb_idx];
    acc = longint'(blend_q) * longint'(sample_t'(x))
        + longint'(ff_gain_q) * longint'(sample_t'(ff_tap))
        + longint'(fb_gain_q) * longint'(sample_t'(fb_tap));
    q = (acc + 64'sd8192) >>> FRAC_BITS;
    if (q > 32767) y = 16'h7FFF;
    else if (q < -32768) y = 16'h8000;
    else y = q[SAMPLE_W-1:0];
    dry_hist[wr_pos] = x;
    wet_hist[wr_pos] = y;
    wr_pos = wr_pos + 16'd1;
    return y;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      4: return 16'h0000;
      5: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'h0002;
      4: return CFG_DATA_W'($urandom_range(9, 1500));
      5: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    directed_steps.push_back('{1'b1, 1'b0, idx, val, 16'h0000});
  endtask

  task automatic add_hit(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] want);
    directed_steps.push_back('{1'b0, 1'b1, REG_BLEND_GAIN, x, want});
  endtask

  task automatic add_run(input logic [SAMPLE_W-1:0] x);
    directed_steps.push_back('{1'b0, 1'b0, REG_BLEND_GAIN, x, 16'h0000});
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_BLEND_GAIN:        blend_q = val;
      REG_FEEDBACK_GAIN:     fb_gain_q = val;
      REG_FEEDFORWARD_GAIN:  ff_gain_q = val;
      REG_FEEDBACK_DELAY:    fb_delay_q = val;
      REG_FEEDFORWARD_DELAY: ff_delay_q = val;
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] x, input logic fixed,
                             input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] y;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample_in = x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    y = comb_predict(x);
    pending_samples.push_back(fixed ? want : y);
    @(negedge clk);
  endtask

  // hold off the result channel in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] exp_sample;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, actual %0d",
                 $time, $signed(out_sample_out));
        mismatches++;
      end else begin
        exp_sample = pending_samples.pop_front();
        if (out_sample_out !== exp_sample) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, $signed(exp_sample), $signed(out_sample_out));
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("universal_comb_filter verification failed");
    $finish;
  end

  initial begin
    step_t row;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      dry_hist[i] = '0;
      wet_hist[i] = '0;
    end
    wr_pos = '0;
    blend_q = BLEND_GAIN_RST;
    fb_gain_q = '0;
    ff_gain_q = '0;
    fb_delay_q = DELAY_RST;
    ff_delay_q = DELAY_RST;

    add_hit(16'h0000, 16'h0000);
    add_hit(16'h7FFF, 16'h7FFF);
    add_hit(16'h8000, 16'h8000);
    add_hit(16'h0001, 16'h0001);
    add_hit(16'hFFFF, 16'hFFFF);
    add_hit(16'h5555, 16'h5555);
    add_hit(16'hAAAA, 16'hAAAA);
    add_cfg(REG_BLEND_GAIN, 16'hC000);
    add_hit(16'h8000, 16'h7FFF);
    add_hit(16'h7FFF, 16'h8001);
    add_cfg(REG_BLEND_GAIN, 16'h7FFF);
    add_hit(16'h7FFF, 16'h7FFF);
    add_hit(16'h8000, 16'h8000);
    add_cfg(REG_BLEND_GAIN, 16'h8000);
    add_hit(16'h8000, 16'h7FFF);
    add_cfg(REG_BLEND_GAIN, 16'h2000);
    add_hit(16'h0001, 16'h0001);
    add_hit(16'hFFFF, 16'h0000);
    add_hit(16'h0003, 16'h0002);
    add_cfg(REG_BLEND_GAIN, 16'h0000);
    add_cfg(REG_FEEDFORWARD_GAIN, 16'h4000);
    add_cfg(REG_FEEDFORWARD_DELAY, 16'h0001);
    add_run(16'h04D2);
    add_run(16'hFFFF);
    add_cfg(REG_FEEDFORWARD_DELAY, 16'h0000);
    add_run(16'h0F0F);
    add_cfg(REG_FEEDFORWARD_DELAY, 16'hFFFF);
    add_cfg(REG_FEEDBACK_GAIN, 16'h4000);
    add_cfg(REG_FEEDBACK_DELAY, 16'h0001);
    add_run(16'h0064);
    add_run(16'hFF9C);
    add_cfg(REG_FEEDBACK_GAIN, 16'hC000);
    add_cfg(REG_FEEDBACK_DELAY, 16'h0002);
    add_run(16'h7FFF);
    add_run(16'h8000);
    add_cfg(REG_SPARE_FIRST, 16'h1234);
    add_cfg(REG_SPARE_LAST, 16'hFFFF);
    add_run(16'h0001);
    add_cfg(REG_FEEDBACK_DELAY, 16'h0000);
    add_run(16'h4000);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    gap_pct = 20;
    stall_pct = 20;
    for (int r = 0; r < directed_steps.size(); r++) begin
      row = directed_steps[r];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        push_sample(row.val, row.fixed, row.want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == RAND_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      write_reg(REG_BLEND_GAIN, pick_gain());
      write_reg(REG_FEEDBACK_GAIN, pick_gain());
      write_reg(REG_FEEDFORWARD_GAIN, pick_gain());
      write_reg(REG_FEEDBACK_DELAY, pick_delay());
      write_reg(REG_FEEDFORWARD_DELAY, pick_delay());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) push_sample(pick_sample(), 1'b0, 16'h0000);
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("universal_comb_filter verification clean");
    end else begin
      $display("universal_comb_filter verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ucf_pkg.sv
design/universal_comb_filter.sv
verif/tb_universal_comb_filter.sv
